// ----- hw/rtl/tbec_pkg.sv -----
// ----------------------------------------------------------------------------
// tbec_pkg
// Shared types and constants of the backslash escape / unescape codec.
// ----------------------------------------------------------------------------
package tbec_pkg;

  // Configuration
  localparam int unsigned MAX_EXTRA_DEF = 8;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CNT_W         = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE        = 2'd0,
    CFG_EXTRA_CHARS = 2'd1,
    CFG_EXTRA_COUNT = 2'd2
  } cfg_idx_e;

  localparam logic MODE_ESCAPE   = 1'b0;
  localparam logic MODE_UNESCAPE = 1'b1;

  // Characters
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_NL         = 8'h0A;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_N          = 8'h6E;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_R          = 8'h72;

  // Result queue
  localparam int unsigned RES_DEPTH = 3;
  localparam int unsigned RES_CNT_W = 2;

  typedef struct packed {
    logic       bad_escape;
    logic       string_last;
    logic       run_last;
    logic [7:0] out_byte;
  } result_t;

  typedef struct packed {
    logic pending;
    logic discarding;
  } codec_state_t;

  // Results of one input byte, in order res0 then res1
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } res_push_t;

endpackage

// ----- hw/rtl/tbec_decode.sv -----
// ----------------------------------------------------------------------------
// tbec_decode
// Escape / unescape decision for one byte: results and next codec state.
// ----------------------------------------------------------------------------
module tbec_decode #(
  parameter int unsigned MaxExtra = tbec_pkg::MAX_EXTRA_DEF
) (
  input  logic [7:0]                 byte_i,
  input  logic                       eos_i,
  input  logic                       mode_i,
  input  logic [8*MaxExtra-1:0]      extra_chars_i,
  input  logic [tbec_pkg::CNT_W-1:0] extra_count_i,
  input  tbec_pkg::codec_state_t     state_i,
  output tbec_pkg::codec_state_t     state_o,
  output tbec_pkg::res_push_t        push_o
);
  import tbec_pkg::*;

  logic extra_hit;

  // Compare against each active extra byte; lanes past MaxExtra never exist
  always_comb begin
    extra_hit = 1'b0;
    for (int k = 0; k < MaxExtra; k++) begin
      if ((CNT_W'(k) < extra_count_i) && (extra_chars_i[8*k +: 8] == byte_i)) begin
        extra_hit = 1'b1;
      end
    end
  end

  always_comb begin
    logic       two;
    logic       ok;
    logic [7:0] second;
    logic [7:0] r;
    result_t    err;

    two     = 1'b0;
    ok      = 1'b1;
    second  = byte_i;
    r       = byte_i;
    err     = '{bad_escape: 1'b1, string_last: 1'b1, run_last: 1'b1, out_byte: 8'h00};
    state_o = state_i;
    push_o  = '0;

    if (state_i.discarding) begin
      // Drop bytes up to the end of the string
      if (eos_i) begin
        state_o = '0;
      end
    end else if (mode_i == MODE_ESCAPE) begin
      state_o.pending = 1'b0;
      two = 1'b1;
      case (byte_i)
        CH_SPACE: begin
          second = CH_UNDERSCORE;
          two    = 1'b0;
        end
        CH_NL:  second = CH_N;
        CH_TAB: second = CH_T;
        CH_CR:  second = CH_R;
        CH_UNDERSCORE, CH_STAR, CH_BSLASH: second = byte_i;
        default: two = extra_hit;
      endcase
      if (two) begin
        push_o.n    = 2'd2;
        push_o.res0 = '{bad_escape: 1'b0, string_last: 1'b0, run_last: 1'b0,
                        out_byte: CH_BSLASH};
        push_o.res1 = '{bad_escape: 1'b0, string_last: eos_i, run_last: 1'b1,
                        out_byte: second};
      end else begin
        push_o.n    = 2'd1;
        push_o.res0 = '{bad_escape: 1'b0, string_last: eos_i, run_last: 1'b1,
                        out_byte: second};
      end
    end else if (!state_i.pending) begin
      if (byte_i == CH_BSLASH) begin
        if (eos_i) begin
          // Trailing backslash
          push_o.n    = 2'd1;
          push_o.res0 = err;
        end else begin
          state_o.pending = 1'b1;
        end
      end else begin
        push_o.n    = 2'd1;
        push_o.res0 = '{bad_escape: 1'b0, string_last: eos_i, run_last: 1'b1,
                        out_byte: (byte_i == CH_UNDERSCORE) ? CH_SPACE : byte_i};
      end
    end else begin
      state_o.pending = 1'b0;
      case (byte_i)
        CH_N: r = CH_NL;
        CH_T: r = CH_TAB;
        CH_R: r = CH_CR;
        CH_UNDERSCORE, CH_STAR, CH_BSLASH: r = byte_i;
        default: ok = extra_hit;
      endcase
      push_o.n = 2'd1;
      if (ok) begin
        push_o.res0 = '{bad_escape: 1'b0, string_last: eos_i, run_last: 1'b1,
                        out_byte: r};
      end else begin
        push_o.res0        = err;
        state_o.discarding = !eos_i;
      end
    end
  end

endmodule

// ----- hw/rtl/tbec_res_fifo.sv -----
// ----------------------------------------------------------------------------
// tbec_res_fifo
// Three-entry shifting result queue: takes up to two results, emits one.
// ----------------------------------------------------------------------------
module tbec_res_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tbec_pkg::res_push_t            push_i,
  input  logic                           pop_ready_i,
  output logic                           valid_o,
  output tbec_pkg::result_t              head_o,
  output logic [tbec_pkg::RES_CNT_W-1:0] cnt_o
);
  import tbec_pkg::*;

  result_t [RES_DEPTH-1:0] ent_q, ent_d;
  logic [RES_CNT_W-1:0]    cnt_q, cnt_d;
  logic                    pop;
  logic [RES_CNT_W-1:0]    base;

  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[0];
  assign cnt_o   = cnt_q;
  assign pop     = valid_o && pop_ready_i;
  assign base    = cnt_q - RES_CNT_W'(pop);

  always_comb begin
    ent_d = ent_q;
    // Advance the queue on a transfer
    if (pop) begin
      for (int i = 0; i < RES_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    for (int i = 0; i < RES_DEPTH; i++) begin
      if ((push_i.n != 2'd0) && (RES_CNT_W'(i) == base)) begin
        ent_d[i] = push_i.res0;
      end
      if ((push_i.n == 2'd2) && ((RES_CNT_W+1)'(i) == ({1'b0, base} + 3'd1))) begin
        ent_d[i] = push_i.res1;
      end
    end
    cnt_d = base + push_i.n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ----- hw/rtl/text_backslash_escape_codec.sv -----
// ----------------------------------------------------------------------------
// text_backslash_escape_codec
// Byte stream backslash escape / unescape codec with end-of-string handling.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tdata         tlast          tuser
// s_axis    in         in_byte[7:0]  end_of_string  -
// m_axis    out        out_byte[7:0] string_last    [0] run_last, [1] bad_escape
// cfg       in         cfg_data_i (64b write data), cfg_addr_i register index
//
// Flow: a byte is registered at the input, decoded in one pass and its
// zero, one or two results are written to a three-entry result queue. The
// input stage advances whenever the queue has room for the byte's results,
// so one-result bytes stream at one per cycle while the output is ready,
// and two-result bytes (escape of a special character) are held back by the
// single output port of the queue. Reset clears the codec state, the config
// and both stages; an output stall backs up into the queue and then stalls
// the input.
// ----------------------------------------------------------------------------
module text_backslash_escape_codec #(
  parameter int unsigned MaxExtra = tbec_pkg::MAX_EXTRA_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input byte stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,   // [7:0] in_byte
  input  logic                            s_axis_tlast_i,   // end_of_string
  // Result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,   // [7:0] out_byte
  output logic                            m_axis_tlast_o,   // string_last
  output logic [1:0]                      m_axis_tuser_o,   // [0] run_last, [1] bad_escape
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tbec_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tbec_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tbec_pkg::*;

  // Config registers
  logic                  mode_q;
  logic [8*MaxExtra-1:0] extra_chars_q;
  logic [CNT_W-1:0]      extra_count_q;

  // Input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;

  codec_state_t          state_q, state_d;
  res_push_t             dec_push, fifo_push;
  result_t               head;
  logic [RES_CNT_W-1:0]  fifo_cnt;
  logic                  advance;

  // Config writes are always taken; software writes only while idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ESCAPE;
      extra_chars_q <= '0;
      extra_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_MODE:        mode_q        <= cfg_data_i[0];
        CFG_EXTRA_CHARS: extra_chars_q <= cfg_data_i[8*MaxExtra-1:0];
        CFG_EXTRA_COUNT: extra_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  tbec_decode #(
    .MaxExtra(MaxExtra)
  ) u_decode (
    .byte_i        (in_byte_q),
    .eos_i         (in_eos_q),
    .mode_i        (mode_q),
    .extra_chars_i (extra_chars_q),
    .extra_count_i (extra_count_q),
    .state_i       (state_q),
    .state_o       (state_d),
    .push_o        (dec_push)
  );

  // Advance the held byte once the queue has room for all of its results
  assign advance = in_valid_q &&
                   (({1'b0, fifo_cnt} + {1'b0, dec_push.n}) <= (RES_CNT_W+1)'(RES_DEPTH));
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    fifo_push = dec_push;
    if (!advance) begin
      fifo_push.n = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Hold the payload unless a new byte transfers in
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_eos_q  <= s_axis_tlast_i;
    end
  end

  tbec_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .pop_ready_i (m_axis_tready_i),
    .valid_o     (m_axis_tvalid_o),
    .head_o      (head),
    .cnt_o       (fifo_cnt)
  );

  assign m_axis_tdata_o = head.out_byte;
  assign m_axis_tlast_o = head.string_last;
  assign m_axis_tuser_o = {head.bad_escape, head.run_last};

endmodule

// ----- hw/rtl/tbec_checker.sv -----
// ----------------------------------------------------------------------------
// tbec_checker
// Port-level checks of the codec, bound to the top level.
// ----------------------------------------------------------------------------
module tbec_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [1:0] m_axis_tuser_o
);

  // Error results close both the run and the string, with a zero byte
  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |->
      (m_axis_tlast_o && m_axis_tuser_o[0] && (m_axis_tdata_o == 8'h00)))
    else $error("error result without string end or with nonzero byte");

  // The last result of a string is also the last of its byte
  a_str_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o[0])
    else $error("string end without run end");

  // Nothing is offered while in reset
  a_rst_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
       $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind text_backslash_escape_codec tbec_checker u_tbec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
